// File: sv/utf8_pre_tokenizer_split_assert.svh
// Assertion macros for the UTF-8 pre-tokenizer splitter
`ifndef UTF8_PRE_TOKENIZER_SPLIT_ASSERT_SVH
`define UTF8_PRE_TOKENIZER_SPLIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define UPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UPS_ASSERT(lbl, prop, msg)
`define UPS_ASSERT_IMPL(lbl, ante, cons, msg)
`define UPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/utf8ps_pkg.sv
// ----------------------------------------------------------------------------
// utf8ps_pkg
// Types, codepoint range tables and helper functions for the splitter.
// ----------------------------------------------------------------------------
`default_nettype none
package utf8ps_pkg;

    typedef enum logic [2:0] {
        KIND_LETTER,
        KIND_NUMBER,
        KIND_OTHER,
        KIND_CONTR,
        KIND_NONE,
        KIND_SPACE
    } kind_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [3:0]      first;
        logic [3:0][1:0] kind;
        logic [2:0]      count;
    } results_t;

    localparam logic [7:0] APOS = 8'h27;
    localparam logic [20:0] REPL_CP = 21'h0FFFD;

    localparam logic [20:0] SPACE_PTS [13] = '{
        21'h20, 21'h09, 21'h0A, 21'h0D, 21'h0B, 21'h0C, 21'h85, 21'hA0,
        21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000};

    localparam logic [20:0] LETTER_LO [30] = '{
        21'h41, 21'h61, 21'hB5, 21'hC0, 21'hD8, 21'hF8, 21'h370, 21'h48A,
        21'h531, 21'h600, 21'h900, 21'hE00, 21'h10A0, 21'h13A0, 21'h1C90,
        21'h1D00, 21'h1D6B, 21'h1D79, 21'h1E00, 21'h1F18, 21'h1F20, 21'h2C00,
        21'h3040, 21'h30A0, 21'h3400, 21'h4E00, 21'hAC00, 21'hFB00,
        21'h10000, 21'h20000};
    localparam logic [20:0] LETTER_HI [30] = '{
        21'h5A, 21'h7A, 21'hB5, 21'hD6, 21'hF6, 21'h2AF, 21'h481, 21'h52F,
        21'h588, 21'h6FF, 21'h97F, 21'hE7F, 21'h10C5, 21'h13F5, 21'h1CBF,
        21'h1D2B, 21'h1D77, 21'h1D9A, 21'h1F15, 21'h1F1D, 21'h1F45, 21'h2C5F,
        21'h309F, 21'h30FF, 21'h4DBF, 21'h9FFF, 21'hD7AF, 21'hFDFF,
        21'h1007F, 21'h2FA1F};

    localparam logic [20:0] DIGIT_LO [12] = '{
        21'h30, 21'h660, 21'h6F0, 21'h7C0, 21'h966, 21'h9E6, 21'hA66, 21'hAE6,
        21'hB66, 21'hBE6, 21'hC66, 21'hFF10};
    localparam logic [20:0] DIGIT_HI [12] = '{
        21'h39, 21'h669, 21'h6F9, 21'h7C9, 21'h96F, 21'h9EF, 21'hA6F, 21'hAEF,
        21'hB6F, 21'hBEF, 21'hC6F, 21'hFF19};

    function automatic kind_t classify(input logic [20:0] cp);
        logic sp;
        logic lt;
        logic dg;
        kind_t k;
        sp = (cp >= 21'h2000) && (cp <= 21'h200A);
        lt = 1'b0;
        dg = 1'b0;
        for (int i = 0; i < 13; i++)
            sp = sp | (cp == SPACE_PTS[i]);
        for (int i = 0; i < 30; i++)
            lt = lt | ((cp >= LETTER_LO[i]) && (cp <= LETTER_HI[i]));
        for (int i = 0; i < 12; i++)
            dg = dg | ((cp >= DIGIT_LO[i]) && (cp <= DIGIT_HI[i]));
        if (sp)
            k = KIND_SPACE;
        else if (lt)
            k = KIND_LETTER;
        else if (dg)
            k = KIND_NUMBER;
        else
            k = KIND_OTHER;
        return k;
    endfunction

    // unit length from lead byte, 0 for an invalid lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        if (b[7] == 1'b0)
            n = 3'd1;
        else if ((b & 8'hE0) == 8'hC0)
            n = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            n = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            n = 3'd4;
        else
            n = 3'd0;
        return n;
    endfunction

    function automatic logic [20:0] decode(input logic [2:0] len, input logic [7:0] b0,
                                           input logic [7:0] b1, input logic [7:0] b2,
                                           input logic [7:0] b3);
        logic [20:0] cp;
        unique case (len)
            3'd1:    cp = {13'd0, b0};
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        endcase
        return cp;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'd32 : b;
    endfunction

endpackage
`default_nettype wire

// File: sv/utf8ps_core.sv
// ----------------------------------------------------------------------------
// utf8ps_core
// Resolves the held bytes plus one new byte into kept result bytes and the
// next lookahead state.
// ----------------------------------------------------------------------------
`default_nettype none
module utf8ps_core
    import utf8ps_pkg::*;
(
    input  wire logic [3:0][7:0] held_bytes,
    input  wire logic [2:0]      held_count,
    input  wire kind_t           open_kind,
    input  wire logic [7:0]      in_byte,
    input  wire logic            text_last,
    output results_t             res,
    output logic [3:0][7:0]      held_bytes_next,
    output logic [2:0]           held_count_next,
    output kind_t                open_kind_next
);

    logic [7:0]  bufb [4];
    logic [2:0]  n;
    logic [2:0]  need_a [4];
    kind_t       kfull_a [4];
    logic [7:0]  w [4];
    logic [3:0]  em;
    logic [3:0]  fi;
    logic [1:0]  ki [4];

    always_comb
    begin
        n = (held_count < 3'd4) ? held_count + 3'd1 : 3'd4;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < held_count)
                bufb[i] = held_bytes[i];
            else if (3'(i) == held_count)
                bufb[i] = in_byte;
            else
                bufb[i] = 8'd0;
        end
        for (int p = 0; p < 4; p++)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = (p + j < 4) ? bufb[2'(p + j)] : 8'd0;
            need_a[p] = lead_len(w[0]);
            kfull_a[p] = classify(decode(need_a[p], w[0], w[1], w[2], w[3]));
        end
    end

    always_comb
    begin
        logic [2:0] p;
        logic [2:0] rem;
        logic [2:0] need;
        logic [2:0] size;
        logic [2:0] clen;
        logic [2:0] elen;
        logic [2:0] t1;
        logic [2:0] t2;
        logic [2:0] idx;
        logic [2:0] cnt;
        logic [7:0] lead;
        logic [7:0] c1;
        logic [7:0] want;
        logic       stop;
        logic       cwait;
        logic       efirst;
        logic       emit_now;
        kind_t      kind;
        kind_t      ekind;
        kind_t      open;
        p = 3'd0;
        stop = 1'b0;
        open = open_kind;
        em = 4'd0;
        fi = 4'd0;
        res = '0;
        for (int k = 0; k < 4; k++)
            ki[k] = 2'd0;
        for (int it = 0; it < 4; it++)
        begin
            rem = n - p;
            lead = bufb[p[1:0]];
            need = need_a[p[1:0]];
            size = 3'd1;
            kind = KIND_OTHER;
            clen = 3'd0;
            cwait = 1'b0;
            c1 = 8'd0;
            want = 8'd0;
            emit_now = 1'b0;
            elen = 3'd0;
            efirst = 1'b0;
            ekind = KIND_OTHER;
            t1 = p + 3'd1;
            t2 = p + 3'd2;
            if (!stop && (p < n))
            begin
                if (need == 3'd0)
                begin
                    size = 3'd1;
                    kind = KIND_OTHER;
                end
                else if (need > rem)
                begin
                    stop = !text_last;
                    size = 3'd1;
                    kind = KIND_OTHER;
                end
                else
                begin
                    size = need;
                    kind = kfull_a[p[1:0]];
                end
                if (!stop)
                begin
                    if (kind == KIND_SPACE)
                    begin
                        open = KIND_NONE;
                        p = p + size;
                    end
                    else
                    begin
                        if (lead == APOS)
                        begin
                            if (rem < 3'd2)
                                cwait = !text_last;
                            else
                            begin
                                c1 = bufb[t1[1:0]];
                                if (c1 == "s" || c1 == "t" || c1 == "m" || c1 == "d")
                                    clen = 3'd2;
                                else if (c1 == "r" || c1 == "v" || c1 == "l")
                                begin
                                    want = (c1 == "l") ? 8'h6C : 8'h65;
                                    if (rem < 3'd3)
                                        cwait = !text_last;
                                    else if (bufb[t2[1:0]] == want)
                                        clen = 3'd3;
                                end
                            end
                        end
                        if (cwait)
                            stop = 1'b1;
                        else if (clen != 3'd0)
                        begin
                            emit_now = 1'b1;
                            elen = clen;
                            efirst = 1'b1;
                            ekind = KIND_CONTR;
                        end
                        else
                        begin
                            emit_now = 1'b1;
                            elen = size;
                            efirst = !((open == kind) &&
                                       (kind == KIND_LETTER || kind == KIND_OTHER));
                            ekind = kind;
                        end
                        if (emit_now)
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                if ((3'(k) >= p) && (3'(k) < p + elen))
                                begin
                                    em[k] = 1'b1;
                                    fi[k] = (3'(k) == p) && efirst;
                                    ki[k] = 2'(ekind);
                                end
                            end
                            open = ekind;
                            p = p + elen;
                        end
                    end
                end
            end
        end

        cnt = 3'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (em[k])
            begin
                res.bytes[cnt[1:0]] = to_lower(bufb[k]);
                res.first[cnt[1:0]] = fi[k];
                res.kind[cnt[1:0]] = ki[k];
                cnt = cnt + 3'd1;
            end
        end
        res.count = cnt;

        for (int i = 0; i < 4; i++)
        begin
            idx = 3'(i) + p;
            held_bytes_next[i] = (idx < 3'd4) ? bufb[idx[1:0]] : 8'd0;
        end
        if (text_last)
        begin
            held_count_next = 3'd0;
            open_kind_next = KIND_NONE;
        end
        else
        begin
            held_count_next = n - p;
            open_kind_next = open;
        end
    end

endmodule
`default_nettype wire

// File: sv/utf8ps_outq.sv
// ----------------------------------------------------------------------------
// utf8ps_outq
// Result register bank: holds the results of one input transaction and
// hands them out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module utf8ps_outq
    import utf8ps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire results_t   load_res,
    input  wire logic       load_end,
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            piece_first,
    output logic [1:0]      piece_kind,
    output logic            run_last,
    output logic            text_end
);

    results_t   q_res_reg;
    logic       q_end_reg;
    logic [1:0] rd_reg;
    logic [2:0] left_reg;
    logic       take;

    assign out_valid   = (left_reg != 3'd0);
    assign take        = out_valid && !out_stall;
    assign room        = (left_reg == 3'd0) || ((left_reg == 3'd1) && !out_stall);
    assign out_byte    = q_res_reg.bytes[rd_reg];
    assign piece_first = q_res_reg.first[rd_reg];
    assign piece_kind  = q_res_reg.kind[rd_reg];
    assign run_last    = (left_reg == 3'd1);
    assign text_end    = (left_reg == 3'd1) && q_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= 2'd0;
            left_reg <= 3'd0;
        end
        else if (load)
        begin
            rd_reg   <= 2'd0;
            left_reg <= load_res.count;
        end
        else if (take)
        begin
            rd_reg   <= rd_reg + 2'd1;
            left_reg <= left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_res_reg <= load_res;
            q_end_reg <= load_end;
        end
    end

endmodule
`default_nettype wire

// File: sv/utf8_pre_tokenizer_split.sv
// Splits a UTF-8 byte stream into CLIP-style pre-token pieces. One input
// transaction is taken per cycle while out_stall is low and each byte
// releases at most one kept byte; a byte that releases more (up to four,
// when it completes a unit or a contraction check) stalls the input until
// its last kept byte is taken at the output, as the result register bank
// hands out one transaction per cycle while out_stall is low.
// ----------------------------------------------------------------------------
// utf8_pre_tokenizer_split
// Top level: lookahead registers, resolve logic and result register bank.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_pre_tokenizer_split_assert.svh"
module utf8_pre_tokenizer_split
    import utf8ps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       text_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            piece_first,
    output logic [1:0]      piece_kind,
    output logic            run_last,
    output logic            text_end
);

    logic [3:0][7:0] held_bytes_reg;
    logic [3:0][7:0] held_bytes_next;
    logic [2:0]      held_count_reg;
    logic [2:0]      held_count_next;
    kind_t           open_kind_reg;
    kind_t           open_kind_next;
    results_t        res;
    logic            room;
    logic            in_accept;

    assign in_stall  = !room;
    assign in_accept = in_valid && room;

    utf8ps_core u_core (
        .held_bytes      (held_bytes_reg),
        .held_count      (held_count_reg),
        .open_kind       (open_kind_reg),
        .in_byte         (in_byte),
        .text_last       (text_last),
        .res             (res),
        .held_bytes_next (held_bytes_next),
        .held_count_next (held_count_next),
        .open_kind_next  (open_kind_next)
    );

    utf8ps_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_accept),
        .load_res    (res),
        .load_end    (text_last),
        .room        (room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .piece_first (piece_first),
        .piece_kind  (piece_kind),
        .run_last    (run_last),
        .text_end    (text_end)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 3'd0;
            open_kind_reg  <= KIND_NONE;
        end
        else if (in_accept)
        begin
            held_count_reg <= held_count_next;
            open_kind_reg  <= open_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            held_bytes_reg <= held_bytes_next;
    end

    `UPS_ASSERT(a_held_bound, held_count_reg <= 3'd3, "lookahead overfilled")
    `UPS_ASSERT_NEXT(a_text_flush, in_accept && text_last, held_count_reg == 3'd0, "no flush")
    `UPS_ASSERT_NEXT(a_kind_flush, in_accept && text_last, open_kind_reg == KIND_NONE, "open")
    `UPS_ASSERT_IMPL(a_hold_input, out_valid && !run_last, in_stall, "input not held")

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the UTF-8 pre-token splitter. Texts are sent one byte
// per transaction, a local model predicts each kept byte with its piece tags,
// and a monitor compares every result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import utf8ps_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic [1:0] kind;
        logic       rlast;
        logic       tend;
    } piece_byte_t;

    localparam int IDLE_LIMIT = 2000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       text_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       piece_first;
    logic [1:0] piece_kind;
    logic       run_last;
    logic       text_end;

    piece_byte_t pending_pieces[$];
    logic [7:0]  la_buf[4];
    int          la_count;
    kind_t       cur_kind;
    int          err_count;
    int          idle_cycles;
    bit          quiet;

    utf8_pre_tokenizer_split DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_byte(in_byte), .text_last(text_last), .out_valid(out_valid),
        .out_stall(out_stall), .out_byte(out_byte), .piece_first(piece_first),
        .piece_kind(piece_kind), .run_last(run_last), .text_end(text_end)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    function automatic kind_t cp_kind(input logic [20:0] cp);
        logic [20:0] sp[13];
        logic [20:0] lt[30][2];
        logic [20:0] dg[12][2];
        sp = '{'h20, 'h09, 'h0A, 'h0D, 'h0B, 'h0C, 'h85, 'hA0, 'h2028, 'h2029,
               'h202F, 'h205F, 'h3000};
        lt = '{'{'h41, 'h5A}, '{'h61, 'h7A}, '{'hB5, 'hB5}, '{'hC0, 'hD6},
               '{'hD8, 'hF6}, '{'hF8, 'h2AF}, '{'h370, 'h481}, '{'h48A, 'h52F},
               '{'h531, 'h588}, '{'h600, 'h6FF}, '{'h900, 'h97F}, '{'hE00, 'hE7F},
               '{'h10A0, 'h10C5}, '{'h13A0, 'h13F5}, '{'h1C90, 'h1CBF},
               '{'h1D00, 'h1D2B}, '{'h1D6B, 'h1D77}, '{'h1D79, 'h1D9A},
               '{'h1E00, 'h1F15}, '{'h1F18, 'h1F1D}, '{'h1F20, 'h1F45},
               '{'h2C00, 'h2C5F}, '{'h3040, 'h309F}, '{'h30A0, 'h30FF},
               '{'h3400, 'h4DBF}, '{'h4E00, 'h9FFF}, '{'hAC00, 'hD7AF},
               '{'hFB00, 'hFDFF}, '{'h10000, 'h1007F}, '{'h20000, 'h2FA1F}};
        dg = '{'{'h30, 'h39}, '{'h660, 'h669}, '{'h6F0, 'h6F9}, '{'h7C0, 'h7C9},
               '{'h966, 'h96F}, '{'h9E6, 'h9EF}, '{'hA66, 'hA6F}, '{'hAE6, 'hAEF},
               '{'hB66, 'hB6F}, '{'hBE6, 'hBEF}, '{'hC66, 'hC6F}, '{'hFF10, 'hFF19}};
        if (cp >= 'h2000 && cp <= 'h200A)
            return KIND_SPACE;
        foreach (sp[i])
            if (cp == sp[i])
                return KIND_SPACE;
        foreach (lt[i])
            if (cp >= lt[i][0] && cp <= lt[i][1])
                return KIND_LETTER;
        foreach (dg[i])
            if (cp >= dg[i][0] && cp <= dg[i][1])
                return KIND_NUMBER;
        return KIND_OTHER;
    endfunction

    function automatic int unit_len(input logic [7:0] b);
        if (b < 8'h80)
            return 1;
        if (b[7:5] == 3'b110)
            return 2;
        if (b[7:4] == 4'b1110)
            return 3;
        if (b[7:3] == 5'b11110)
            return 4;
        return 0;
    endfunction

    task automatic push_kept(input int n, input bit first, input kind_t k,
                             ref piece_byte_t res[$]);
        piece_byte_t p;
        for (int i = 0; i < n && i < 4; i++)
        begin
            p.b = (la_buf[i] >= 8'h41 && la_buf[i] <= 8'h5A) ? la_buf[i] + 8'd32
                                                            : la_buf[i];
            p.first = first && i == 0;
            p.kind = k[1:0];
            p.rlast = 1'b0;
            p.tend = 1'b0;
            res.push_back(p);
        end
    endtask

    task automatic drop_front(input int n);
        if (n > la_count)
            n = la_count;
        for (int i = 0; i < 4; i++)
            la_buf[i] = (i + n < 4) ? la_buf[i + n] : 8'h00;
        la_count -= n;
    endtask

    // contraction length at front: 2, 3, 0 none, -1 wait for more
    function automatic int apos_len(input bit last);
        logic [7:0] want;
        if (la_count < 2)
            return last ? 0 : -1;
        if (la_buf[1] inside {"s", "t", "m", "d"})
            return 2;
        if (la_buf[1] == "r" || la_buf[1] == "v")
            want = "e";
        else if (la_buf[1] == "l")
            want = "l";
        else
            return 0;
        if (la_count < 3)
            return last ? 0 : -1;
        return la_buf[2] == want ? 3 : 0;
    endfunction

    task automatic predict_split(input logic [7:0] b, input bit last);
        piece_byte_t res[$];
        int          need;
        int          sz;
        int          c;
        logic [20:0] cp;
        kind_t       k;
        logic [7:0]  lead;
        if (la_count < 4)
        begin
            la_buf[la_count] = b;
            la_count++;
        end
        while (la_count > 0)
        begin
            lead = la_buf[0];
            need = unit_len(lead);
            if (need == 0)
            begin
                sz = 1;
                cp = REPL_CP;
            end
            else if (la_count < need)
            begin
                if (!last)
                    break;
                sz = 1;
                cp = REPL_CP;
            end
            else
            begin
                sz = need;
                case (need)
                    1: cp = {13'd0, la_buf[0]};
                    2: cp = {10'd0, la_buf[0][4:0], la_buf[1][5:0]};
                    3: cp = {5'd0, la_buf[0][3:0], la_buf[1][5:0], la_buf[2][5:0]};
                    default: cp = {la_buf[0][2:0], la_buf[1][5:0], la_buf[2][5:0],
                                   la_buf[3][5:0]};
                endcase
            end
            k = cp_kind(cp);
            if (k == KIND_SPACE)
            begin
                cur_kind = KIND_NONE;
                drop_front(sz);
                continue;
            end
            if (sz == 1 && lead == APOS)
            begin
                c = apos_len(last);
                if (c < 0)
                    break;
                if (c > 0)
                begin
                    push_kept(c, 1'b1, KIND_CONTR, res);
                    cur_kind = KIND_CONTR;
                    drop_front(c);
                    continue;
                end
            end
            push_kept(sz, !(cur_kind == k && (k == KIND_LETTER || k == KIND_OTHER)),
                      k, res);
            cur_kind = k;
            drop_front(sz);
        end
        if (last)
        begin
            cur_kind = KIND_NONE;
            la_count = 0;
        end
        if (res.size() > 5)
            res = res[0:4];
        if (res.size() > 0)
        begin
            res[$].rlast = 1'b1;
            res[$].tend = last;
        end
        foreach (res[i])
            pending_pieces.push_back(res[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        text_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_split(b, last);
        @(negedge clk);
    endtask

    task automatic send_text(input logic [7:0] t[$]);
        foreach (t[i])
            send_byte(t[i], i == t.size() - 1);
    endtask

    always @(posedge clk)
    begin
        piece_byte_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pieces.size() == 0)
                report_mismatch("unexpected out_byte", out_byte, 0);
            else
            begin
                e = pending_pieces.pop_front();
                if (out_byte !== e.b)
                    report_mismatch("out_byte", out_byte, e.b);
                if (piece_first !== e.first)
                    report_mismatch("piece_first", piece_first, e.first);
                if (piece_kind !== e.kind)
                    report_mismatch("piece_kind", piece_kind, e.kind);
                if (run_last !== e.rlast)
                    report_mismatch("run_last", run_last, e.rlast);
                if (text_end !== e.tend)
                    report_mismatch("text_end", text_end, e.tend);
            end
        end
    end

    always
    begin
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL utf8_pre_tokenizer_split");
            $finish;
        end
    end

    task automatic test_ascii_pieces();
        send_text('{"I", "'", "l", "l", " ", "W", "e", "'", "v", "e", "!", "?"});
        send_text('{"Z", "a", "1", "2", "'", "s", "'", "t", "'", "m", "'", "d"});
        send_text('{"'", "r", "e", "'", "r", "x", "'", "l"});
        send_text('{"'"});
        send_text('{8'h00, 8'h7F, 8'h09, 8'h0A, 8'h0D, "@", "["});
    endtask

    task automatic test_multibyte();
        send_text('{8'hC3, 8'hA9, 8'hE4, 8'hB8, 8'h80, 8'hF0, 8'hA0, 8'h80, 8'h80});
        send_text('{8'hEF, 8'hBC, 8'h91, 8'hE2, 8'h80, 8'h83, 8'hC2, 8'hA0, "x"});
        send_text('{8'h80, 8'hBF, 8'hF8, 8'hFF, "a", 8'hE3, 8'h81});
        send_text('{8'hF4, 8'h8F, 8'hBF});
        send_text('{8'hC0});
    endtask

    task automatic test_random_texts();
        logic [7:0] t[$];
        logic [7:0] pool[14];
        int         sent;
        int         n;
        pool = '{"a", "B", "7", "'", "s", "l", "r", "e", "v", " ", ",", "t", "m", "d"};
        sent = 0;
        while (sent < 280)
        begin
            if (sent > 230)
                quiet = 1'b1;
            t.delete();
            n = $urandom_range(1, 14);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: t.push_back(pool[$urandom_range(0, 13)]);
                    5:
                    begin
                        t.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                        t.push_back(8'h80 | 8'($urandom_range(0, 63)));
                    end
                    6:
                    begin
                        t.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                        t.push_back(8'h80 | 8'($urandom_range(0, 63)));
                        t.push_back(8'h80 | 8'($urandom_range(0, 63)));
                    end
                    7:
                    begin
                        t.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                        repeat (3) t.push_back(8'h80 | 8'($urandom_range(0, 63)));
                    end
                    default: t.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            sent += t.size();
            send_text(t);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        text_last = 1'b0;
        out_stall = 1'b0;
        la_count = 0;
        la_buf = '{default: 8'h00};
        cur_kind = KIND_NONE;
        err_count = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_ascii_pieces();
        test_multibyte();
        test_random_texts();
        in_valid <= 1'b0;
        while (pending_pieces.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("PASS utf8_pre_tokenizer_split");
        else
            $display("FAIL utf8_pre_tokenizer_split");
        $finish;
    end
endmodule
`default_nettype wire
